// ===== rtl/adaptive_torus_route_select_defines.svh =====
// ---------------------------------------------------------------------------
// Adaptive torus route select: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_TORUS_ROUTE_SELECT_DEFINES_SVH
`define ADAPTIVE_TORUS_ROUTE_SELECT_DEFINES_SVH

`ifndef SYNTHESIS
`define ATRS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ATRS_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ATRS_ASSERT(lbl, clk, rst, prop, msg)
`define ATRS_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/atrs_pkg.sv =====
// ---------------------------------------------------------------------------
// Adaptive torus route select: package
// Widths, register indexes and pipeline stage types.
// ---------------------------------------------------------------------------
package atrs_pkg;

   localparam int MAX_DIMS   = 3;
   localparam int DIMS_DEF   = 3;
   localparam int RADIX_DEF  = 16;
   localparam int COORD_W    = 4;
   localparam int LOAD_W     = 8;
   localparam int DIM_W      = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_OWN_COORD_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_COORD_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_COORD_2 = 2'd2;

   typedef struct packed {
      logic [MAX_DIMS-1:0][COORD_W-1:0] mag;
      logic [MAX_DIMS-1:0]              neg;
      logic [MAX_DIMS-1:0]              rdy;
   } s1_type;

   typedef struct packed {
      logic [MAX_DIMS-1:0][MAX_DIMS-1:0] prec;
      logic [MAX_DIMS-1:0]               neg;
      logic [MAX_DIMS-1:0]               rdy;
   } s2_type;

endpackage

// ===== rtl/adaptive_torus_route_select.sv =====
// ---------------------------------------------------------------------------
// Adaptive torus route select
// Minimal adaptive route choice with misrouting on zero offset, three stages.
// ---------------------------------------------------------------------------
// Channel  Handshake               Payload
// req      start / busy            dest coords, ready masks, channel loads
// rsp      rsp_valid strobe        route_found, out_dimension, out_negative
// csr      csr_valid / csr_ready   csr_index, csr_wdata (own coordinates)
//
// One transaction per clock; the result is registered through the
// offset/direction, ordering compare and priority select stages.
// busy stays low; the response side cannot stall, so nothing is held back.
// Reset clears the stage valid bits and the own-coordinate registers.
// ---------------------------------------------------------------------------
`include "adaptive_torus_route_select_defines.svh"

module adaptive_torus_route_select
   import atrs_pkg::*;
#(
   parameter int DIMS  = DIMS_DEF,
   parameter int RADIX = RADIX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [COORD_W-1:0]   req_dest_coord_0,
   input  logic [COORD_W-1:0]   req_dest_coord_1,
   input  logic [COORD_W-1:0]   req_dest_coord_2,
   input  logic [MAX_DIMS-1:0]  req_pos_ready,
   input  logic [MAX_DIMS-1:0]  req_neg_ready,
   input  logic [LOAD_W-1:0]    req_pos_load_0,
   input  logic [LOAD_W-1:0]    req_pos_load_1,
   input  logic [LOAD_W-1:0]    req_pos_load_2,
   input  logic [LOAD_W-1:0]    req_neg_load_0,
   input  logic [LOAD_W-1:0]    req_neg_load_1,
   input  logic [LOAD_W-1:0]    req_neg_load_2,
   output logic                 rsp_valid,
   output logic                 rsp_route_found,
   output logic [DIM_W-1:0]     rsp_out_dimension,
   output logic                 rsp_out_negative,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   localparam logic [COORD_W-1:0] CMAX =
      (RADIX >= (1 << COORD_W)) ? {COORD_W{1'b1}} : COORD_W'(RADIX - 1);

   logic [COORD_W-1:0] own_ff [MAX_DIMS];
   logic [COORD_W-1:0] own_in [MAX_DIMS];
   logic [COORD_W-1:0] dest   [MAX_DIMS];
   logic [LOAD_W-1:0]  pload  [MAX_DIMS];
   logic [LOAD_W-1:0]  nload  [MAX_DIMS];

   logic    s1_valid_ff, s1_valid_in;
   logic    s2_valid_ff, s2_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   logic                 found_ff, found_in;
   logic [DIM_W-1:0]     dim_ff, dim_in;
   logic                 neg_ff, neg_in;
   logic [MAX_DIMS-1:0]  win;
   logic                 accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign dest[0]  = req_dest_coord_0;
   assign dest[1]  = req_dest_coord_1;
   assign dest[2]  = req_dest_coord_2;
   assign pload[0] = req_pos_load_0;
   assign pload[1] = req_pos_load_1;
   assign pload[2] = req_pos_load_2;
   assign nload[0] = req_neg_load_0;
   assign nload[1] = req_neg_load_1;
   assign nload[2] = req_neg_load_2;

   // own coordinates
   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         own_in[d] = own_ff[d];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_OWN_COORD_0: own_in[0] = csr_wdata;
            REG_OWN_COORD_1: own_in[1] = csr_wdata;
            REG_OWN_COORD_2: own_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: offset, magnitude, direction, ready of chosen direction
   always_comb begin
      logic [COORD_W-1:0] ds, os;
      logic signed [COORD_W:0] diff;
      s1_in = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         ds   = (dest[d] > CMAX) ? CMAX : dest[d];
         os   = (own_ff[d] > CMAX) ? CMAX : own_ff[d];
         diff = $signed({1'b0, ds}) - $signed({1'b0, os});
         s1_in.mag[d] = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
         if (diff[COORD_W]) begin
            s1_in.neg[d] = 1'b1;
         end else if (diff == '0) begin
            s1_in.neg[d] = pload[d] > nload[d];
         end else begin
            s1_in.neg[d] = 1'b0;
         end
         if (d < DIMS) begin
            s1_in.rdy[d] = s1_in.neg[d] ? req_neg_ready[d] : req_pos_ready[d];
         end
      end
   end

   // stage 2: visiting order as pairwise precedence
   always_comb begin
      s2_in     = '0;
      s2_in.neg = s1_ff.neg;
      s2_in.rdy = s1_ff.rdy;
      for (int d = 0; d < MAX_DIMS; d++) begin
         for (int e = 0; e < MAX_DIMS; e++) begin
            s2_in.prec[d][e] = (s1_ff.mag[d] > s1_ff.mag[e]) ||
                               ((s1_ff.mag[d] == s1_ff.mag[e]) && (d < e));
         end
      end
   end

   // stage 3: first ready channel in visiting order
   always_comb begin
      found_in = 1'b0;
      dim_in   = '0;
      neg_in   = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         win[d] = s2_ff.rdy[d];
         for (int e = 0; e < MAX_DIMS; e++) begin
            if (e != d && s2_ff.rdy[e] && !s2_ff.prec[d][e]) begin
               win[d] = 1'b0;
            end
         end
         if (win[d]) begin
            found_in = 1'b1;
            dim_in   = DIM_W'(d);
            neg_in   = s2_ff.neg[d];
         end
      end
   end

   assign s1_valid_in  = accept;
   assign s2_valid_in  = s1_valid_ff;
   assign rsp_valid_in = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            own_ff[d] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int d = 0; d < MAX_DIMS; d++) begin
            own_ff[d] <= own_in[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      found_ff <= found_in;
      dim_ff   <= dim_in;
      neg_ff   <= neg_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_route_found   = found_ff;
   assign rsp_out_dimension = dim_ff;
   assign rsp_out_negative  = neg_ff;

   `ATRS_ASSERT(a_latency, clock, reset, accept |-> ##3 rsp_valid, "result missing after three cycles")
   `ATRS_ASSERT(a_stage_flow, clock, reset, s2_valid_ff |=> rsp_valid, "stage 2 transaction lost")
   `ATRS_ASSERT(a_one_winner, clock, reset, $onehot0(win), "more than one channel selected")
   `ATRS_ASSERT(a_no_route_zero, clock, reset, (rsp_valid && !rsp_route_found) |-> (rsp_out_dimension == '0 && !rsp_out_negative), "no-route result not cleared")
   `ATRS_NEVER(a_dim_range, clock, reset, rsp_valid && rsp_route_found && (rsp_out_dimension >= DIMS), "dimension out of range")

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// Adaptive torus route select: testbench
// Drives route requests under several own-coordinate settings, predicts each
// routing decision from offsets, ready masks and loads, and checks every
// response in order.
// ---------------------------------------------------------------------------
module tb_top
   import atrs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_DIMS     = DIMS_DEF;
   localparam int N_PHASES   = 9;
   localparam int PHASE_ITEMS = 106;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [MAX_DIMS-1:0][COORD_W-1:0] dest;
      logic [MAX_DIMS-1:0]              pos_rdy;
      logic [MAX_DIMS-1:0]              neg_rdy;
      logic [MAX_DIMS-1:0][LOAD_W-1:0]  pload;
      logic [MAX_DIMS-1:0][LOAD_W-1:0]  nload;
   } route_req_type;

   typedef struct packed {
      logic             found;
      logic [DIM_W-1:0] dim;
      logic             negative;
   } route_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [COORD_W-1:0]   req_dest_coord_0 = '0;
   logic [COORD_W-1:0]   req_dest_coord_1 = '0;
   logic [COORD_W-1:0]   req_dest_coord_2 = '0;
   logic [MAX_DIMS-1:0]  req_pos_ready = '0;
   logic [MAX_DIMS-1:0]  req_neg_ready = '0;
   logic [LOAD_W-1:0]    req_pos_load_0 = '0;
   logic [LOAD_W-1:0]    req_pos_load_1 = '0;
   logic [LOAD_W-1:0]    req_pos_load_2 = '0;
   logic [LOAD_W-1:0]    req_neg_load_0 = '0;
   logic [LOAD_W-1:0]    req_neg_load_1 = '0;
   logic [LOAD_W-1:0]    req_neg_load_2 = '0;
   logic                 rsp_valid;
   logic                 rsp_route_found;
   logic [DIM_W-1:0]     rsp_out_dimension;
   logic                 rsp_out_negative;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_wdata = '0;

   route_req_type pending_req_q[$];
   route_rsp_type route_exp_q[$];
   logic [MAX_DIMS-1:0][COORD_W-1:0] own_coord_mdl = '0;
   logic req_taken = 1'b0;
   bit   gaps_on = 1'b1;
   int   gap_left = 0;
   int   fail_cnt = 0;
   int   checked_cnt = 0;
   int   routed_cnt = 0;
   int   idle_cycles = 0;

   adaptive_torus_route_select uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_dest_coord_0  (req_dest_coord_0),
      .req_dest_coord_1  (req_dest_coord_1),
      .req_dest_coord_2  (req_dest_coord_2),
      .req_pos_ready     (req_pos_ready),
      .req_neg_ready     (req_neg_ready),
      .req_pos_load_0    (req_pos_load_0),
      .req_pos_load_1    (req_pos_load_1),
      .req_pos_load_2    (req_pos_load_2),
      .req_neg_load_0    (req_neg_load_0),
      .req_neg_load_1    (req_neg_load_1),
      .req_neg_load_2    (req_neg_load_2),
      .rsp_valid         (rsp_valid),
      .rsp_route_found   (rsp_route_found),
      .rsp_out_dimension (rsp_out_dimension),
      .rsp_out_negative  (rsp_out_negative),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Largest offset first, lower dimension on equal magnitude; a zero
   // offset misroutes towards the lighter load, positive on a tie.
   function automatic route_rsp_type route_predict(
         route_req_type rq, logic [MAX_DIMS-1:0][COORD_W-1:0] own);
      route_rsp_type rs;
      int  diff [MAX_DIMS];
      int  mag [MAX_DIMS];
      bit  go_neg [MAX_DIMS];
      int  rank;
      bit  hit;
      rs  = '0;
      hit = 1'b0;
      for (int d = 0; d < N_DIMS; d++) begin
         diff[d]   = int'(rq.dest[d]) - int'(own[d]);
         mag[d]    = (diff[d] < 0) ? -diff[d] : diff[d];
         go_neg[d] = (diff[d] < 0) ? 1'b1 :
                     (diff[d] > 0) ? 1'b0 : (rq.pload[d] > rq.nload[d]);
      end
      for (int r = 0; r < N_DIMS && !hit; r++) begin
         for (int d = 0; d < N_DIMS && !hit; d++) begin
            rank = 0;
            for (int j = 0; j < N_DIMS; j++) begin
               if (mag[j] > mag[d] || (mag[j] == mag[d] && j < d)) rank++;
            end
            if (rank == r && (go_neg[d] ? rq.neg_rdy[d] : rq.pos_rdy[d])) begin
               hit         = 1'b1;
               rs.found    = 1'b1;
               rs.dim      = DIM_W'(d);
               rs.negative = go_neg[d];
            end
         end
      end
      return rs;
   endfunction

   function automatic route_req_type mk_req(int c0, int c1, int c2, int prdy, int nrdy,
                                            int pl, int nl);
      route_req_type rq;
      rq.dest    = {COORD_W'(c2), COORD_W'(c1), COORD_W'(c0)};
      rq.pos_rdy = MAX_DIMS'(prdy);
      rq.neg_rdy = MAX_DIMS'(nrdy);
      rq.pload   = {3{LOAD_W'(pl)}};
      rq.nload   = {3{LOAD_W'(nl)}};
      return rq;
   endfunction

   function automatic route_req_type rand_req(logic [MAX_DIMS-1:0][COORD_W-1:0] own);
      route_req_type rq;
      int r;
      for (int d = 0; d < MAX_DIMS; d++) begin
         r = $urandom_range(0, 9);
         if (r < 3)      rq.dest[d] = own[d];
         else if (r < 4) rq.dest[d] = $urandom_range(0, 1) ? '1 : '0;
         else            rq.dest[d] = COORD_W'($urandom);
         r = $urandom_range(0, 9);
         rq.pload[d] = LOAD_W'($urandom);
         if (r < 3)      rq.nload[d] = rq.pload[d];
         else if (r < 4) begin
            rq.pload[d] = $urandom_range(0, 1) ? '1 : '0;
            rq.nload[d] = $urandom_range(0, 1) ? '1 : '0;
         end else        rq.nload[d] = LOAD_W'($urandom);
      end
      r = $urandom_range(0, 19);
      if (r < 2)      {rq.pos_rdy, rq.neg_rdy} = '0;
      else if (r < 5) {rq.pos_rdy, rq.neg_rdy} = '1;
      else            {rq.pos_rdy, rq.neg_rdy} = 6'($urandom);
      return rq;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Driver
   always @(negedge clock) begin
      route_req_type nxt;
      if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_req_q.size() > 0) begin
            nxt = pending_req_q.pop_front();
            req_dest_coord_0 <= nxt.dest[0];
            req_dest_coord_1 <= nxt.dest[1];
            req_dest_coord_2 <= nxt.dest[2];
            req_pos_ready    <= nxt.pos_rdy;
            req_neg_ready    <= nxt.neg_rdy;
            req_pos_load_0   <= nxt.pload[0];
            req_pos_load_1   <= nxt.pload[1];
            req_pos_load_2   <= nxt.pload[2];
            req_neg_load_0   <= nxt.nload[0];
            req_neg_load_1   <= nxt.nload[1];
            req_neg_load_2   <= nxt.nload[2];
            start <= 1'b1;
            if (!gaps_on) gap_left = 0;
            else begin
               case ($urandom_range(0, 99)) inside
                  [0:54]:  gap_left = 0;
                  [55:86]: gap_left = $urandom_range(1, 3);
                  [87:97]: gap_left = $urandom_range(4, 12);
                  default: gap_left = $urandom_range(20, 60);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor, predictor and checker
   always @(posedge clock) begin
      route_req_type rq;
      route_rsp_type exp_rsp;
      req_taken <= start && !busy && !reset;
      if (!reset && rsp_valid) begin
         if (route_exp_q.size() == 0) begin
            $display("%0t: response with nothing outstanding: found=%0b dim=%0d neg=%0b",
                     $realtime, rsp_route_found, rsp_out_dimension, rsp_out_negative);
            fail_cnt++;
         end else begin
            exp_rsp = route_exp_q.pop_front();
            checked_cnt++;
            if (exp_rsp.found) routed_cnt++;
            if (rsp_route_found !== exp_rsp.found) begin
               $display("%0t: route_found expected %0b actual %0b",
                        $realtime, exp_rsp.found, rsp_route_found);
               fail_cnt++;
            end
            if (rsp_out_dimension !== exp_rsp.dim) begin
               $display("%0t: out_dimension expected %0d actual %0d",
                        $realtime, exp_rsp.dim, rsp_out_dimension);
               fail_cnt++;
            end
            if (rsp_out_negative !== exp_rsp.negative) begin
               $display("%0t: out_negative expected %0b actual %0b",
                        $realtime, exp_rsp.negative, rsp_out_negative);
               fail_cnt++;
            end
         end
      end
      if (!reset && start && !busy) begin
         rq.dest    = {req_dest_coord_2, req_dest_coord_1, req_dest_coord_0};
         rq.pos_rdy = req_pos_ready;
         rq.neg_rdy = req_neg_ready;
         rq.pload   = {req_pos_load_2, req_pos_load_1, req_pos_load_0};
         rq.nload   = {req_neg_load_2, req_neg_load_1, req_neg_load_0};
         route_exp_q.push_back(route_predict(rq, own_coord_mdl));
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_OWN_COORD_0: own_coord_mdl[0] = csr_wdata;
            REG_OWN_COORD_1: own_coord_mdl[1] = csr_wdata;
            REG_OWN_COORD_2: own_coord_mdl[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [MAX_DIMS-1:0][COORD_W-1:0] own_set;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         while (pending_req_q.size() != 0 || start || route_exp_q.size() != 0)
            @(posedge clock);
         repeat (4) @(posedge clock);
         case (ph)
            0:       own_set = {4'd5, 4'd8, 4'd7};
            1:       own_set = '0;
            2:       own_set = '1;
            3:       own_set = {4'd8, 4'd0, 4'd15};
            4:       own_set = {4'd3, 4'd15, 4'd0};
            default: own_set = 12'($urandom);
         endcase
         csr_write(REG_OWN_COORD_0, own_set[0]);
         csr_write(REG_OWN_COORD_1, own_set[1]);
         csr_write(REG_OWN_COORD_2, own_set[2]);
         @(negedge clock);
         csr_valid <= 1'b0;
         gaps_on = (ph % 3 != 2);
         if (ph == 0) begin
            // own coordinates (7, 8, 5)
            pending_req_q.push_back(mk_req(7, 8, 5, 7, 7, 0, 0));
            pending_req_q.push_back(mk_req(7, 8, 5, 7, 7, 255, 0));
            pending_req_q.push_back(mk_req(7, 8, 5, 0, 7, 0, 255));
            pending_req_q.push_back(mk_req(15, 0, 15, 7, 7, 0, 0));
            pending_req_q.push_back(mk_req(15, 0, 15, 3, 7, 0, 0));
            pending_req_q.push_back(mk_req(15, 0, 15, 2, 0, 0, 0));
            pending_req_q.push_back(mk_req(15, 0, 15, 0, 2, 0, 0));
            pending_req_q.push_back(mk_req(0, 0, 0, 7, 4, 0, 0));
            pending_req_q.push_back(mk_req(0, 0, 0, 0, 3, 0, 0));
            pending_req_q.push_back(mk_req(15, 15, 15, 0, 0, 255, 255));
            pending_req_q.push_back(mk_req(7, 0, 5, 1, 0, 10, 10));
            pending_req_q.push_back(mk_req(7, 0, 5, 0, 1, 11, 10));
            pending_req_q.push_back(mk_req(7, 8, 5, 4, 0, 200, 255));
            pending_req_q.push_back(mk_req(7, 8, 5, 0, 4, 255, 254));
            pending_req_q.push_back(mk_req(15, 15, 15, 2, 7, 0, 0));
            pending_req_q.push_back(mk_req(15, 15, 15, 6, 0, 0, 0));
            pending_req_q.push_back(mk_req(0, 15, 0, 7, 0, 128, 127));
            pending_req_q.push_back(mk_req(8, 7, 5, 7, 7, 1, 0));
            pending_req_q.push_back(mk_req(6, 9, 5, 7, 5, 0, 1));
            pending_req_q.push_back(mk_req(7, 9, 4, 1, 6, 0, 0));
         end else begin
            for (int n = 0; n < PHASE_ITEMS; n++) pending_req_q.push_back(rand_req(own_set));
         end
      end
      while (pending_req_q.size() != 0 || start || route_exp_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Checked %0d route decisions across %0d own-coordinate settings", checked_cnt,
               N_PHASES);
      $display("  %0d routed, %0d with no ready channel", routed_cnt, checked_cnt - routed_cnt);
      if (fail_cnt == 0 && route_exp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
